FILE: rtl/usb_midi_sysex_command_deframer_top_assert.svh
// Assertion macros shared by the SysEx deframer RTL.
`ifndef USB_MIDI_SYSEX_COMMAND_DEFRAMER_TOP_ASSERT_SVH
`define USB_MIDI_SYSEX_COMMAND_DEFRAMER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define USMD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define USMD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/usmd_pkg.sv
// Shared types, constants and parameter defaults of the SysEx deframer.
package usmd_pkg;

   // Parameter defaults
   localparam int BUFFER_BYTES_DEF  = 128;
   localparam int PROGRAM_SLOTS_DEF = 4;

   // Message layout
   localparam int HDR_LEN     = 8;
   localparam int HDR_IDX_W   = $clog2(HDR_LEN);
   localparam int MIN_LEN     = HDR_LEN + 1;
   localparam int WRITE_LEN   = 110;
   localparam int LANES       = 3;
   localparam int MAX_RESULTS = LANES + 1;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 8;

   // Header bytes
   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] MAKER_ID     = 8'h47;
   localparam logic [7:0] MODEL_ID     = 8'h7C;
   localparam logic [7:0] CMD_WRITE    = 8'h61;
   localparam logic [7:0] CMD_SELECT   = 8'h62;
   localparam logic [7:0] CMD_DUMP     = 8'h63;

   // Event code index values
   localparam logic [3:0] CIN_CONT  = 4'h4;
   localparam logic [3:0] CIN_END1  = 4'h5;
   localparam logic [3:0] CIN_END2  = 4'h6;
   localparam logic [3:0] CIN_END3  = 4'h7;

   // Result kinds
   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_SELECT  = 3'd1;
   localparam logic [2:0] KIND_WRITE   = 3'd2;
   localparam logic [2:0] KIND_DUMP    = 3'd3;
   localparam logic [2:0] KIND_IGNORED = 3'd4;

   typedef struct packed {
      logic [3:0] code_index;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] byte_offset;
      logic [7:0] data_value;
      logic [1:0] program_slot;
      logic [7:0] device_id;
      logic       last;
   } rsp_type;

   // What one lane did with its byte
   typedef struct packed {
      logic                 emit;
      logic                 hdr_we;
      logic [HDR_IDX_W-1:0] hdr_idx;
      logic [6:0]           offset;
      logic [7:0]           data;
   } lane_out_type;

endpackage

FILE: rtl/usmd_lane.sv
// One append lane: places one event byte in the header or emits it as payload.
module usmd_lane #(
   parameter int BUFFER_BYTES = usmd_pkg::BUFFER_BYTES_DEF,
   parameter int CountW       = $clog2(BUFFER_BYTES + 1)
) (
   input  logic                  enable,
   input  logic [CountW-1:0]     pos,
   input  logic [7:0]            data,
   output logic [CountW-1:0]     pos_next,
   output usmd_pkg::lane_out_type lane_out
);
   import usmd_pkg::*;

   // Wrap on a full buffer, else store header bytes and emit the rest
   always_comb begin
      pos_next         = pos;
      lane_out.emit    = 1'b0;
      lane_out.hdr_we  = 1'b0;
      lane_out.hdr_idx = pos[HDR_IDX_W-1:0];
      lane_out.offset  = pos[6:0];
      lane_out.data    = data;
      if (enable) begin
         if (pos >= CountW'(BUFFER_BYTES)) begin
            pos_next = '0;
         end else begin
            pos_next = pos + CountW'(1);
            if (pos < CountW'(HDR_LEN)) begin
               lane_out.hdr_we = 1'b1;
            end else begin
               lane_out.emit = 1'b1;
            end
         end
      end
   end

endmodule

FILE: rtl/usmd_merge.sv
// Merge stage: forwards header writes, decodes the command, packs the result list.
module usmd_merge #(
   parameter int BUFFER_BYTES  = usmd_pkg::BUFFER_BYTES_DEF,
   parameter int PROGRAM_SLOTS = usmd_pkg::PROGRAM_SLOTS_DEF,
   parameter int CountW        = $clog2(BUFFER_BYTES + 1)
) (
   input  usmd_pkg::lane_out_type                 lanes [usmd_pkg::LANES],
   input  logic                                   end_msg,
   input  logic [CountW-1:0]                      count,
   input  logic [usmd_pkg::HDR_LEN-1:0][7:0]      hdr_cur,
   input  logic [7:0]                             dev_cur,
   output logic [usmd_pkg::HDR_LEN-1:0][7:0]      hdr_next,
   output logic [7:0]                             dev_next,
   output usmd_pkg::rsp_type                      res [usmd_pkg::MAX_RESULTS],
   output logic [usmd_pkg::RES_CNT_W-1:0]         res_cnt
);
   import usmd_pkg::*;

   logic                 hdr_ok;
   logic                 slot_ok;
   logic [2:0]           kind;
   rsp_type              cand [MAX_RESULTS];
   logic [RES_CNT_W-1:0] idx;

   // Apply this event's header writes in lane order
   always_comb begin
      hdr_next = hdr_cur;
      for (int i = 0; i < LANES; i++) begin
         if (lanes[i].hdr_we) begin
            hdr_next[lanes[i].hdr_idx] = lanes[i].data;
         end
      end
   end

   // Check header and decode the command
   always_comb begin
      hdr_ok = end_msg && (count >= CountW'(MIN_LEN)) &&
               (hdr_next[0] == SYSEX_START) && (hdr_next[1] == MAKER_ID) &&
               (hdr_next[3] == MODEL_ID);
      slot_ok  = {1'b0, hdr_next[7]} < 9'(PROGRAM_SLOTS);
      dev_next = hdr_ok ? hdr_next[2] : dev_cur;
      kind     = KIND_IGNORED;
      if (hdr_ok && slot_ok) begin
         case (hdr_next[4])
            CMD_SELECT: kind = KIND_SELECT;
            CMD_WRITE:  kind = (count == CountW'(WRITE_LEN)) ? KIND_WRITE : KIND_IGNORED;
            CMD_DUMP:   kind = KIND_DUMP;
            default:    kind = KIND_IGNORED;
         endcase
      end
   end

   // Build candidates: lane payloads, then the command result
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         cand[i].kind         = KIND_PAYLOAD;
         cand[i].byte_offset  = lanes[i].offset;
         cand[i].data_value   = lanes[i].data;
         cand[i].program_slot = '0;
         cand[i].device_id    = '0;
         cand[i].last         = 1'b0;
      end
      cand[LANES].kind         = kind;
      cand[LANES].byte_offset  = '0;
      cand[LANES].data_value   = '0;
      cand[LANES].program_slot = (kind == KIND_IGNORED) ? 2'd0 : hdr_next[7][1:0];
      cand[LANES].device_id    = dev_next;
      cand[LANES].last         = 1'b0;
   end

   // Pack valid candidates to the front and flag the final one
   always_comb begin
      idx = '0;
      for (int j = 0; j < MAX_RESULTS; j++) begin
         res[j] = cand[LANES];
      end
      for (int i = 0; i < LANES; i++) begin
         if (lanes[i].emit) begin
            res[idx[1:0]] = cand[i];
            idx           = idx + RES_CNT_W'(1);
         end
      end
      if (end_msg) begin
         res[idx[1:0]] = cand[LANES];
         idx           = idx + RES_CNT_W'(1);
      end
      for (int j = 0; j < MAX_RESULTS; j++) begin
         res[j].last = (RES_CNT_W'(j + 1) == idx);
      end
      res_cnt = idx;
   end

endmodule

FILE: rtl/usmd_rsp_queue.sv
// Result queue: takes up to four results per request, hands out one per cycle unless stalled.
module usmd_rsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  usmd_pkg::rsp_type               push_data [usmd_pkg::MAX_RESULTS],
   input  logic [usmd_pkg::RES_CNT_W-1:0]  push_cnt,
   output logic                            room,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output usmd_pkg::rsp_type               rsp_data
);
   import usmd_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   rsp_type          entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  add_cnt;
   logic             pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign room      = (count_ff <= CntW'(QUEUE_DEPTH - MAX_RESULTS));
   assign add_cnt   = push ? CntW'(push_cnt) : '0;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(add_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + add_cnt - (pop ? CntW'(1) : CntW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the packed results of one request
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (push && (RES_CNT_W'(i) < push_cnt)) begin
            entry_ff[wr_ptr_ff + PtrW'(i)] <= push_data[i];
         end
      end
   end

endmodule

FILE: rtl/usb_midi_sysex_command_deframer_top.sv
// Top level of the USB-MIDI SysEx command deframer.
//
// Takes one USB-MIDI event per request and appends its 1 to 3 bytes through three
// side-by-side lanes; a merge stage decodes the message end and packs the results
// (payload bytes at offset 8 and up, then one command result on an end code) into
// an eight-entry result queue that hands out one result per cycle unless stalled.
// A request is taken in any cycle in which the queue has room for four results, so
// a new event enters while earlier results still drain. Each of an event's results
// (up to four) takes its own turn on the result port, so the queue's single read
// port sets the sustained rate.
`include "usb_midi_sysex_command_deframer_top_assert.svh"

module usb_midi_sysex_command_deframer_top #(
   parameter int BUFFER_BYTES  = usmd_pkg::BUFFER_BYTES_DEF,
   parameter int PROGRAM_SLOTS = usmd_pkg::PROGRAM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  usmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output usmd_pkg::rsp_type rsp_data
);
   import usmd_pkg::*;

   localparam int CountW = $clog2(BUFFER_BYTES + 1);

   logic [CountW-1:0]         byte_count_ff, byte_count_in;
   logic [HDR_LEN-1:0][7:0]   header_store_ff, header_store_in;
   logic [7:0]                device_id_ff, device_id_in;
   logic                      accept;
   logic                      room;
   logic                      end_msg;
   logic [LANES-1:0]          lane_en;
   logic [7:0]                lane_byte [LANES];
   logic [CountW-1:0]         pos [LANES+1];
   lane_out_type              lane_res [LANES];
   rsp_type                   res [MAX_RESULTS];
   logic [RES_CNT_W-1:0]      res_cnt;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   // Decode which lanes take a byte and whether the message ends
   always_comb begin
      lane_en = '0;
      end_msg = 1'b0;
      case (req_data.code_index)
         CIN_CONT: lane_en = 3'b111;
         CIN_END1: begin
            lane_en = 3'b001;
            end_msg = 1'b1;
         end
         CIN_END2: begin
            lane_en = 3'b011;
            end_msg = 1'b1;
         end
         CIN_END3: begin
            lane_en = 3'b111;
            end_msg = 1'b1;
         end
         default: lane_en = '0;
      endcase
   end

   assign lane_byte[0] = req_data.first_byte;
   assign lane_byte[1] = req_data.second_byte;
   assign lane_byte[2] = req_data.third_byte;
   assign pos[0]       = byte_count_ff;

   // Byte lanes, chained on the running count
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      usmd_lane #(
         .BUFFER_BYTES (BUFFER_BYTES)
      ) u_lane (
         .enable   (lane_en[g]),
         .pos      (pos[g]),
         .data     (lane_byte[g]),
         .pos_next (pos[g+1]),
         .lane_out (lane_res[g])
      );
   end

   usmd_merge #(
      .BUFFER_BYTES  (BUFFER_BYTES),
      .PROGRAM_SLOTS (PROGRAM_SLOTS)
   ) u_merge (
      .lanes    (lane_res),
      .end_msg  (end_msg),
      .count    (pos[LANES]),
      .hdr_cur  (header_store_ff),
      .dev_cur  (device_id_ff),
      .hdr_next (header_store_in),
      .dev_next (device_id_in),
      .res      (res),
      .res_cnt  (res_cnt)
   );

   // Clear the count when a message ends
   assign byte_count_in = end_msg ? '0 : pos[LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         device_id_ff  <= '0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         device_id_ff  <= device_id_in;
      end
   end

   // Hold header bytes; no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         header_store_ff <= header_store_in;
      end
   end

   usmd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (res),
      .push_cnt  (res_cnt),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `USMD_ASSERT_NEXT(a_end_clears_count, accept && end_msg, byte_count_ff == '0,
      "byte count not cleared after message end")
   `USMD_ASSERT_NEXT(a_end_gives_result, accept && end_msg, rsp_valid,
      "message end produced no result")
   `USMD_ASSERT_NOW(a_command_is_last, rsp_valid && (rsp_data.kind != KIND_PAYLOAD),
      rsp_data.last, "command result not flagged last")

endmodule

FILE: verif/tb_usb_midi_sysex_command_deframer_top.sv
// Self-checking testbench for the USB-MIDI SysEx command deframer.
module tb_usb_midi_sysex_command_deframer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import usmd_pkg::*;

   localparam int BUF_BYTES   = BUFFER_BYTES_DEF;
   localparam int SLOT_COUNT  = PROGRAM_SLOTS_DEF;
   localparam int ITEM_TARGET = 330;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 16;

   // Codes outside the SysEx range, used to check that they are dropped
   localparam logic [3:0] CIN_ZERO     = 4'h0;
   localparam logic [3:0] CIN_ALL_ONES = 4'hF;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   usb_midi_sysex_command_deframer_top #(
      .BUFFER_BYTES  (BUF_BYTES),
      .PROGRAM_SLOTS (SLOT_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Stimulus and scoreboard storage
   req_type pending_events[$];
   rsp_type results_due[$];
   int      useful_events = 0;
   int      total_events  = 0;
   int      accepted      = 0;
   int      checked       = 0;
   int      errors        = 0;
   int      cycles        = 0;
   int      kind_tally[5] = '{default: 0};

   // Mirror of the deframer state
   logic [7:0] msg_len      = '0;
   logic [7:0] hdr_bytes[8] = '{default: '0};
   logic [7:0] held_dev_id  = '0;

   // Driver and receiver pacing
   int             burst_left = 1;
   int             gap_left   = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_span = 0;
   int             stall_tick = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Append one byte to the message; return 1 when it leaves as payload
   function automatic bit absorb_byte(input logic [7:0] b, output rsp_type r);
      r = '0;
      if (int'(msg_len) >= BUF_BYTES) begin
         // drop the byte and restart the count
         msg_len = '0;
         return 1'b0;
      end
      if (int'(msg_len) < HDR_LEN) begin
         hdr_bytes[msg_len[2:0]] = b;
         msg_len = msg_len + 8'd1;
         return 1'b0;
      end
      r.kind        = KIND_PAYLOAD;
      r.byte_offset = msg_len[6:0];
      r.data_value  = b;
      msg_len = msg_len + 8'd1;
      return 1'b1;
   endfunction

   // Decode the finished message into its command result
   function automatic rsp_type close_message();
      rsp_type r;
      r = '0;
      r.kind = KIND_IGNORED;
      if (int'(msg_len) >= MIN_LEN && hdr_bytes[0] == SYSEX_START &&
          hdr_bytes[1] == MAKER_ID && hdr_bytes[3] == MODEL_ID) begin
         held_dev_id = hdr_bytes[2];
         if (int'(hdr_bytes[7]) < SLOT_COUNT) begin
            case (hdr_bytes[4])
               CMD_SELECT: r.kind = KIND_SELECT;
               CMD_WRITE: begin
                  if (int'(msg_len) == WRITE_LEN) r.kind = KIND_WRITE;
               end
               CMD_DUMP: r.kind = KIND_DUMP;
               default: r.kind = KIND_IGNORED;
            endcase
            if (r.kind != KIND_IGNORED) r.program_slot = hdr_bytes[7][1:0];
         end
      end
      r.device_id = held_dev_id;
      msg_len = '0;
      return r;
   endfunction

   // Work out the results of one accepted event and queue them
   task automatic deframe_event(input req_type e);
      rsp_type r;
      rsp_type made[$];
      int      i;
      if (e.code_index >= CIN_CONT && e.code_index <= CIN_END3) begin
         if (absorb_byte(e.first_byte, r)) made.push_back(r);
         if (e.code_index != CIN_END1) begin
            if (absorb_byte(e.second_byte, r)) made.push_back(r);
         end
         if (e.code_index == CIN_CONT || e.code_index == CIN_END3) begin
            if (absorb_byte(e.third_byte, r)) made.push_back(r);
         end
         if (e.code_index != CIN_CONT) made.push_back(close_message());
         for (i = 0; i < made.size(); i++) begin
            r = made[i];
            r.last = (i == made.size() - 1);
            results_due.push_back(r);
         end
      end
   endtask

   task automatic push_event(input logic [3:0] code, input logic [7:0] b0,
                             input logic [7:0] b1, input logic [7:0] b2);
      req_type e;
      e.code_index  = code;
      e.first_byte  = b0;
      e.second_byte = b1;
      e.third_byte  = b2;
      pending_events.push_back(e);
      if (code >= CIN_CONT && code <= CIN_END3) useful_events++;
   endtask

   // Build a SysEx message and split it into USB-MIDI events;
   // spoil names a byte to corrupt, or -1 for none
   task automatic send_message(input logic [7:0] cmd, input logic [7:0] dev,
                               input logic [7:0] slot, input int len,
                               input int spoil);
      logic [7:0] body[$];
      logic [7:0] tail[3];
      logic [3:0] end_code;
      int         i;
      int         k;
      int         rest;
      for (i = 0; i < len; i++) begin
         case (i)
            0: body.push_back(SYSEX_START);
            1: body.push_back(MAKER_ID);
            2: body.push_back(dev);
            3: body.push_back(MODEL_ID);
            4: body.push_back(cmd);
            7: body.push_back(slot);
            default: body.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      if (spoil >= 0 && spoil < len) body[spoil] ^= 8'($urandom_range(1, 255));
      i = 0;
      while (len - i > 3) begin
         push_event(CIN_CONT, body[i], body[i+1], body[i+2]);
         i += 3;
      end
      rest = len - i;
      // unused bytes of the closing event carry junk
      for (k = 0; k < 3; k++)
         tail[k] = (i + k < len) ? body[i+k] : 8'($urandom_range(0, 255));
      end_code = (rest == 1) ? CIN_END1 : (rest == 2) ? CIN_END2 : CIN_END3;
      push_event(end_code, tail[0], tail[1], tail[2]);
   endtask

   // Fill the stimulus queue, then wait for the run to drain
   initial begin : stimulus
      int         pick;
      int         len;
      int         spoil;
      logic [7:0] cmd;
      logic [7:0] dev;
      logic [7:0] slot;

      // Directed: codes outside the SysEx range do nothing
      push_event(CIN_ZERO, 8'h00, 8'h00, 8'h00);
      push_event(CIN_ALL_ONES, 8'hFF, 8'hFF, 8'hFF);
      // Lone end events make messages too short to decode
      push_event(CIN_END1, 8'hFF, 8'h00, 8'h00);
      push_event(CIN_END2, 8'h00, 8'h00, 8'hFF);
      push_event(CIN_END3, 8'hFF, 8'hFF, 8'hFF);
      // Shortest valid select, top slot, all-ones device id
      send_message(CMD_SELECT, 8'hFF, 8'(SLOT_COUNT - 1), MIN_LEN, -1);
      // Dump request on slot 0 with a zero device id
      send_message(CMD_DUMP, 8'h00, 8'd0, MIN_LEN + 1, -1);
      // Write of the wrong length is ignored
      send_message(CMD_WRITE, 8'h5A, 8'd1, MIN_LEN + 2, -1);
      // Program out of range: ignored, but the device id is still taken
      send_message(CMD_SELECT, 8'hA5, 8'(SLOT_COUNT), MIN_LEN, -1);
      // Good header one byte short of the minimum
      send_message(CMD_SELECT, 8'h33, 8'd2, HDR_LEN, -1);
      // Unknown command
      send_message(CMD_DUMP + 8'd1, 8'h44, 8'd0, MIN_LEN, -1);
      // Corrupt start byte
      send_message(CMD_SELECT, 8'h55, 8'd1, MIN_LEN, 0);

      // One exact-length write and one overflow up front, then random traffic
      send_message(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)),
                   WRITE_LEN, -1);
      send_message(CMD_SELECT, 8'($urandom_range(0, 255)), 8'd1, BUF_BYTES + 2, -1);

      while (useful_events < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            push_event(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            dev  = 8'($urandom_range(0, 255));
            slot = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, SLOT_COUNT - 1))
                                               : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            cmd  = (pick < 3) ? CMD_WRITE : (pick < 6) ? CMD_SELECT :
                   (pick < 9) ? CMD_DUMP : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               len = $urandom_range(MIN_LEN, 24);
            end else if (pick < 80) begin
               len = $urandom_range(1, HDR_LEN);
            end else if (pick < 92) begin
               len = $urandom_range(WRITE_LEN - 1, WRITE_LEN + 1);
               if ($urandom_range(0, 3) != 0) cmd = CMD_WRITE;
            end else begin
               len = $urandom_range(BUF_BYTES - 2, BUF_BYTES + 12);
            end
            spoil = -1;
            if ($urandom_range(0, 9) == 0) begin
               pick  = $urandom_range(0, 2);
               spoil = (pick == 0) ? 0 : (pick == 1) ? 1 : 3;
            end
            send_message(cmd, dev, slot, len, spoil);
         end
      end
      total_events = pending_events.size();

      while (accepted < total_events || results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d events (%0d in the SysEx range), %0d results checked",
               accepted, useful_events, checked);
      $display("Results by kind: %0d payload, %0d select, %0d write, %0d dump, %0d ignored",
               kind_tally[KIND_PAYLOAD], kind_tally[KIND_SELECT], kind_tally[KIND_WRITE],
               kind_tally[KIND_DUMP], kind_tally[KIND_IGNORED]);
      if (errors == 0 && results_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Present requests in bursts; hold the payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_events.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_events.pop_front();
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel on a pattern that changes from stretch to stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_span = $urandom_range(10, 60);
         end else begin
            stall_span--;
         end
         stall_tick++;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_stall <= (stall_tick % 3 == 0);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // Predict on each accepted request, then compare each accepted result
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         msg_len     = '0;
         held_dev_id = '0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_event(req_data);
            accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (rsp_data.kind <= KIND_IGNORED) kind_tally[rsp_data.kind]++;
            if (results_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result kind=%0d off=%0d data=%h slot=%0d dev=%h last=%0b",
                        $time, rsp_data.kind, rsp_data.byte_offset, rsp_data.data_value,
                        rsp_data.program_slot, rsp_data.device_id, rsp_data.last);
            end else begin
               want = results_due.pop_front();
               if (rsp_data !== want) begin
                  errors++;
                  $display("%0t: mismatch expected kind=%0d off=%0d data=%h slot=%0d dev=%h last=%0b",
                           $time, want.kind, want.byte_offset, want.data_value,
                           want.program_slot, want.device_id, want.last);
                  $display("%0t:          actual   kind=%0d off=%0d data=%h slot=%0d dev=%h last=%0b",
                           $time, rsp_data.kind, rsp_data.byte_offset, rsp_data.data_value,
                           rsp_data.program_slot, rsp_data.device_id, rsp_data.last);
               end
            end
         end
      end
   end

   // End a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles: %0d of %0d events accepted, %0d results owed",
                  cycles, accepted, total_events, results_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/usmd_pkg.sv
rtl/usmd_lane.sv
rtl/usmd_merge.sv
rtl/usmd_rsp_queue.sv
rtl/usb_midi_sysex_command_deframer_top.sv
verif/tb_usb_midi_sysex_command_deframer_top.sv
